### hdl/assert_macros.svh
// assertion macros shared by the rpn stack calculator rtl
// no dependencies; the assertions compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)

`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/rsc_pkg.sv
// shared types, codes and constants of the rpn stack calculator
// no dependencies; imported by every module of the block
package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int MUL_STEPS = 64;
  localparam int DIV_STEPS = 96;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NUM = 2'd0,
    KIND_OP  = 2'd1,
    KIND_END = 2'd2,
    KIND_BAD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_DIV_ZERO  = 3'd3,
    STAT_INVALID   = 3'd4,
    STAT_TOO_FEW   = 3'd5,
    STAT_TOO_MANY  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_R,
    S_RD_L,
    S_MULDIV,
    S_RD_END
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] number;
    logic [1:0]         op;
  } token_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] value;
    logic               finished;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic go;
    logic divide;
  } md_ctl_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

### hdl/rsc_stack.sv
// operand stack storage: one write port and one registered read port
// depends on rsc_pkg
module rsc_stack (
  input  logic              clk,
  input  rsc_pkg::stk_req_t req,
  input  logic [63:0]       wdata,
  output logic [63:0]       rdata
);
  import rsc_pkg::*;

  logic [63:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

### hdl/rsc_muldiv.sv
// iterative fixed-point multiply and divide on one shared 66-bit adder
// shift-add multiply in 64 steps, restoring divide in 96 steps; depends on rsc_pkg
module rsc_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  rsc_pkg::md_ctl_t ctl,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [63:0]      result
);
  import rsc_pkg::*;

  logic              run;
  logic              fin;
  logic              divide_q;
  logic              neg;
  logic              over;
  logic [STEP_W-1:0] step;
  logic [63:0]       base;
  logic [63:0]       opnd;
  logic [63:0]       hi;
  logic [63:0]       lo;

  logic [65:0] add_a;
  logic [65:0] add_b;
  logic [65:0] sum;
  logic [64:0] mul_s;
  logic        ge;
  logic [63:0] hi_next;
  logic [63:0] lo_next;
  logic [63:0] opnd_next;
  logic        over_next;
  logic [63:0] fmag;
  logic        fbig;
  logic [63:0] fval;

  // divide: remainder shifted with next dividend bit minus divisor
  // multiply: partial sum plus multiplicand
  always_comb begin
    add_a = divide_q ? {1'b0, hi, opnd[63]} : {2'b00, hi};
    add_b = divide_q ? ~{2'b00, base} : {2'b00, base};
    sum   = add_a + add_b + {65'd0, divide_q};
    ge    = ~sum[65];
    mul_s = opnd[0] ? sum[64:0] : {1'b0, hi};
    if (divide_q) begin
      hi_next   = ge ? sum[63:0] : {hi[62:0], opnd[63]};
      lo_next   = {lo[62:0], ge};
      opnd_next = {opnd[62:0], 1'b0};
      over_next = over | lo[63];
    end else begin
      hi_next   = mul_s[64:1];
      lo_next   = {mul_s[0], lo[63:1]};
      opnd_next = {1'b0, opnd[63:1]};
      over_next = over;
    end
  end

  always_comb begin
    if (divide_q) begin
      fmag = lo;
      fbig = over;
    end else begin
      fmag = {hi[31:0], lo[63:32]};
      fbig = |hi[63:32];
    end
    if (neg) begin
      fval = (fbig || fmag > SIGN64) ? SIGN64 : (64'd0 - fmag);
    end else begin
      fval = (fbig || fmag[63]) ? MAXPOS : fmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (ctl.go) begin
        run <= 1'b1;
      end else if (run && step == '0) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      divide_q <= ctl.divide;
      neg      <= a[63] ^ b[63];
      base     <= ctl.divide ? mag64(b) : mag64(a);
      opnd     <= ctl.divide ? mag64(a) : mag64(b);
      hi       <= '0;
      lo       <= '0;
      over     <= 1'b0;
      step     <= ctl.divide ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MUL_STEPS - 1);
    end else if (run) begin
      hi   <= hi_next;
      lo   <= lo_next;
      opnd <= opnd_next;
      over <= over_next;
      step <= step - 1'b1;
    end
    if (fin) begin
      result <= fval;
    end
  end

endmodule

### hdl/rpn_stack_calculator_top.sv
// top level of the rpn stack calculator: token sequencer and stack pointer
// depends on rsc_pkg, rsc_stack, rsc_muldiv and assert_macros.svh
//
// One token per transaction: pulse start with a token while busy is low. Each
// token gives exactly one result on result, marked by a one-cycle done pulse
// that cannot be held off, so capture it when it appears. busy rises the cycle
// after the token is taken and falls when done rises. A pushed number or a token
// rejected at dispatch ends in S_DISPATCH, a good end token adds S_RD_END,
// and add, subtract and a divide by zero go on through S_RD_R and S_RD_L;
// multiply and divide wait in S_MULDIV on the shared multiply/divide unit,
// which retires one product or quotient bit per cycle through its single
// 66-bit adder (64 steps for a product, 96 for the Q32.32 quotient). The stack
// sits in a small memory with a registered read port, so each operand fetch
// takes a state of its own. Any error, and every end token, empties the stack.
`include "assert_macros.svh"

module rpn_stack_calculator_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rsc_pkg::token_t  token,
  output logic             busy,
  output logic             done,
  output rsc_pkg::result_t result
);
  import rsc_pkg::*;

  state_t     state;
  state_t     state_next;
  token_t     tok;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [63:0] right_q;
  logic        load_right;

  stk_req_t    stk;
  logic [63:0] wdata;
  logic [63:0] rdata;
  md_ctl_t     md_ctl;
  logic        md_done;
  logic [63:0] md_res;

  logic        emit;
  result_t     res_d;

  logic        full;
  logic        few_ops;
  logic        div_zero;
  logic        is_addsub;
  logic        is_sub;
  logic [63:0] bx;
  logic [63:0] asum;
  logic        aovf;
  logic [63:0] addsub;

  rsc_stack u_stack (
    .clk   (clk),
    .req   (stk),
    .wdata (wdata),
    .rdata (rdata)
  );

  rsc_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctl    (md_ctl),
    .a      (rdata),
    .b      (right_q),
    .done   (md_done),
    .result (md_res)
  );

  assign busy   = (state != S_IDLE);
  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - CNT_W'(2);

  assign full      = (count >= CNT_W'(STACK_DEPTH));
  assign few_ops   = (count < CNT_W'(2));
  assign div_zero  = (tok.op == OP_DIV) && (right_q == '0);
  assign is_addsub = (tok.op == OP_ADD) || (tok.op == OP_SUB);
  assign is_sub    = (tok.op == OP_SUB);

  // saturating add/subtract, left operand straight from the read port
  always_comb begin
    bx     = is_sub ? ~right_q : right_q;
    asum   = rdata + bx + {63'd0, is_sub};
    aovf   = (rdata[63] == bx[63]) && (asum[63] != rdata[63]);
    addsub = aovf ? (rdata[63] ? SIGN64 : MAXPOS) : asum;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (tok.kind)
          KIND_OP:  state_next = few_ops ? S_IDLE : S_RD_R;
          KIND_END: state_next = (count == CNT_W'(1)) ? S_RD_END : S_IDLE;
          default:  state_next = S_IDLE;
        endcase
      end
      S_RD_R: state_next = S_RD_L;
      S_RD_L: begin
        if (div_zero || is_addsub) state_next = S_IDLE;
        else state_next = S_MULDIV;
      end
      S_MULDIV: begin
        if (md_done) state_next = S_IDLE;
      end
      S_RD_END: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stk        = '0;
    wdata      = '0;
    md_ctl     = '0;
    emit       = 1'b0;
    res_d      = '0;
    count_next = count;
    load_right = 1'b0;
    case (state)
      S_DISPATCH: begin
        case (tok.kind)
          KIND_NUM: begin
            emit = 1'b1;
            if (full) begin
              res_d.status   = STAT_OVERFLOW;
              res_d.finished = 1'b1;
              count_next     = '0;
            end else begin
              stk.we     = 1'b1;
              stk.waddr  = count[ADDR_W-1:0];
              wdata      = tok.number;
              count_next = count + 1'b1;
            end
          end
          KIND_OP: begin
            if (few_ops) begin
              emit           = 1'b1;
              res_d.status   = STAT_UNDERFLOW;
              res_d.finished = 1'b1;
              count_next     = '0;
            end else begin
              stk.raddr = cnt_m1[ADDR_W-1:0];
            end
          end
          KIND_END: begin
            if (count == '0) begin
              emit           = 1'b1;
              res_d.status   = STAT_TOO_FEW;
              res_d.finished = 1'b1;
            end else if (count != CNT_W'(1)) begin
              emit           = 1'b1;
              res_d.status   = STAT_TOO_MANY;
              res_d.finished = 1'b1;
              count_next     = '0;
            end
            // single value: bottom entry is read at address zero
          end
          default: begin
            emit           = 1'b1;
            res_d.status   = STAT_INVALID;
            res_d.finished = 1'b1;
            count_next     = '0;
          end
        endcase
      end
      S_RD_R: begin
        load_right = 1'b1;
        stk.raddr  = cnt_m2[ADDR_W-1:0];
      end
      S_RD_L: begin
        if (div_zero) begin
          emit           = 1'b1;
          res_d.status   = STAT_DIV_ZERO;
          res_d.finished = 1'b1;
          count_next     = '0;
        end else if (is_addsub) begin
          emit        = 1'b1;
          res_d.value = addsub;
          stk.we      = 1'b1;
          stk.waddr   = cnt_m2[ADDR_W-1:0];
          wdata       = addsub;
          count_next  = cnt_m1;
        end else begin
          md_ctl.go     = 1'b1;
          md_ctl.divide = (tok.op == OP_DIV);
        end
      end
      S_MULDIV: begin
        if (md_done) begin
          emit        = 1'b1;
          res_d.value = md_res;
          stk.we      = 1'b1;
          stk.waddr   = cnt_m2[ADDR_W-1:0];
          wdata       = md_res;
          count_next  = cnt_m1;
        end
      end
      S_RD_END: begin
        emit           = 1'b1;
        res_d.value    = rdata;
        res_d.finished = 1'b1;
        count_next     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      tok <= token;
    end
    if (load_right) begin
      right_q <= rdata;
    end
    if (emit) begin
      result <= res_d;
    end
  end

  `ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_W'(STACK_DEPTH))
  `ASSERT_IMP(a_error_clears, clk, rst, done && result.status != STAT_OK, count == '0)
  `ASSERT_IMP(a_done_frees, clk, rst, done, !busy)
  `ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMP(a_md_owner, clk, rst, md_done, state == S_MULDIV)

endmodule
